// File: src/i2cm_pkg.sv
// Shared types and constants for the I2C master byte engine.
package i2cm_pkg;

    localparam int CFG_AW = 3;

    localparam logic [7:0] TPU_RESET   = 8'd1;
    localparam logic [7:0] LIMIT_RESET = 8'd250;

    localparam logic REG_TPU   = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    localparam logic [2:0] FN_NONE  = 3'd0;
    localparam logic [2:0] FN_START = 3'd1;
    localparam logic [2:0] FN_STOP  = 3'd2;
    localparam logic [2:0] FN_ACK   = 3'd3;
    localparam logic [2:0] FN_NACK  = 3'd4;
    localparam logic [2:0] FN_WAIT  = 3'd5;
    localparam logic [2:0] FN_WRITE = 3'd6;
    localparam logic [2:0] FN_READ  = 3'd7;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] tx_byte;
        logic       sda_in;
    } t_cmd;

    typedef struct packed {
        logic       no_ack;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_drive;
        logic       sda_out;
        logic       scl_out;
    } t_result;

    localparam int RES_W = $bits(t_result);

endpackage

// File: src/i2c_master_byte_engine_top.sv
// Top level of the I2C master byte engine: stream ports, register port, input stage.
//
// Each input transaction is one time tick of the bus. Input tdata carries tx_byte and
// sda_in; tuser carries the command code, which is taken only while no command is
// running. Every input transaction yields exactly one output transaction holding the
// line levels to drive (scl, sda, drive enable), busy and done flags, the last read byte
// and the no-ack flag, as they stand after that tick.
// Throughput is one tick per cycle while the result queue has room. A tick is held in the
// input register, then passes through the sequencer into the result queue.
// The register port sets ticks per delay unit (address 0) and the ack poll limit
// (address 4); write them only while no command is running.
// Reset puts the bus lines high with SDA released, clears all state and loads the
// register defaults (1 tick per unit, poll limit 250).
// When the receiver stalls, up to two results wait in the queue and one tick waits in
// the input register; then s_axis_tready falls and the sequencer holds.
module i2c_master_byte_engine_top
    import i2cm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [15:0]       s_axis_tdata,  // [7:0] tx_byte, [8] sda_in, [15:9] zero
    input  logic [2:0]        s_axis_tuser,  // [2:0] func
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [15:0]       m_axis_tdata,  // [0] scl_out, [1] sda_out, [2] sda_drive,
                                             // [3] busy_res, [4] done_res,
                                             // [12:5] rx_byte, [13] no_ack, [15:14] zero
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [7:0] r_tpu;
    logic [7:0] r_limit;
    logic       r_in_valid;
    t_cmd       r_in;
    logic       push;
    logic       fifo_full;
    t_result    step_res;
    t_result    out_res;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_LIMIT) ? {24'd0, r_limit} : {24'd0, r_tpu};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tpu   <= TPU_RESET;
            r_limit <= LIMIT_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_TPU:   r_tpu   <= pwdata[7:0];
                REG_LIMIT: r_limit <= pwdata[7:0];
                default:   r_tpu   <= r_tpu;
            endcase
        end
    end

    assign push          = r_in_valid && !fifo_full;
    assign s_axis_tready = !r_in_valid || push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.func    <= s_axis_tuser;
            r_in.tx_byte <= s_axis_tdata[7:0];
            r_in.sda_in  <= s_axis_tdata[8];
        end
    end

    i2cm_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (push),
        .i_cmd    (r_in),
        .i_tpu    (r_tpu),
        .i_limit  (r_limit),
        .o_result (step_res)
    );

    i2cm_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (step_res),
        .o_full  (fifo_full),
        .o_valid (m_axis_tvalid),
        .i_pop   (m_axis_tready),
        .o_data  (out_res)
    );

    assign m_axis_tdata = {{(16 - RES_W){1'b0}}, out_res};

endmodule

// File: src/i2cm_engine.sv
// Per-tick bus sequencer: command decode, delay timing, bit shifting and line levels.
module i2cm_engine
    import i2cm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_cmd       i_cmd,
    input  logic [7:0] i_tpu,
    input  logic [7:0] i_limit,
    output t_result    o_result
);

    localparam logic [4:0] PH_IDLE  = 5'd0;
    localparam logic [4:0] PH_ST1   = 5'd1;
    localparam logic [4:0] PH_ST2   = 5'd2;
    localparam logic [4:0] PH_SP1   = 5'd3;
    localparam logic [4:0] PH_SP2   = 5'd4;
    localparam logic [4:0] PH_AK1   = 5'd5;
    localparam logic [4:0] PH_AK2   = 5'd6;
    localparam logic [4:0] PH_WA1   = 5'd7;
    localparam logic [4:0] PH_WA2   = 5'd8;
    localparam logic [4:0] PH_TO1   = 5'd9;
    localparam logic [4:0] PH_TO2   = 5'd10;
    localparam logic [4:0] PH_WRSET = 5'd11;
    localparam logic [4:0] PH_WRHI  = 5'd12;
    localparam logic [4:0] PH_WRLO  = 5'd13;
    localparam logic [4:0] PH_WREND = 5'd14;
    localparam logic [4:0] PH_RDHI  = 5'd15;
    localparam logic [4:0] PH_RDSMP = 5'd16;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    logic [4:0] r_phase,  n_phase;
    logic [3:0] r_bc,     n_bc;
    logic [7:0] r_timer,  n_timer;
    logic [7:0] r_poll,   n_poll;
    logic [7:0] r_shift,  n_shift;
    logic [7:0] r_rx,     n_rx;
    logic       r_fail,   n_fail;
    logic       r_scl,    n_scl;
    logic       r_sda,    n_sda;
    logic       r_drv,    n_drv;
    logic [1:0] r_units,  n_units;

    logic [7:0] tpu_eff;
    logic [7:0] t_dec;
    logic [1:0] u_dec;
    logic [3:0] bc_inc;
    logic [7:0] sh_in;
    logic       run;
    logic       done;

    always_comb begin
        n_phase = r_phase;
        n_bc    = r_bc;
        n_timer = r_timer;
        n_poll  = r_poll;
        n_shift = r_shift;
        n_rx    = r_rx;
        n_fail  = r_fail;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_drv   = r_drv;
        n_units = r_units;
        done    = 1'b0;
        run     = 1'b0;
        t_dec   = r_timer - 8'd1;
        u_dec   = r_units - 2'd1;
        bc_inc  = r_bc + 4'd1;
        sh_in   = {r_shift[6:0], i_cmd.sda_in};
        tpu_eff = (i_tpu == 8'd0) ? 8'd1 : i_tpu;

        if (r_phase == PH_IDLE) begin
            case (i_cmd.func)
                FN_START: begin
                    n_drv = 1'b1; n_sda = 1'b1; n_scl = 1'b1;
                    n_phase = PH_ST1; n_timer = tpu_eff; n_units = 2'd2;
                end
                FN_STOP: begin
                    n_drv = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
                    n_phase = PH_SP1; n_timer = tpu_eff; n_units = 2'd2;
                end
                FN_ACK, FN_NACK: begin
                    n_scl = 1'b0; n_drv = 1'b1; n_sda = (i_cmd.func == FN_NACK);
                    n_phase = PH_AK1; n_timer = tpu_eff; n_units = 2'd2;
                end
                FN_WAIT: begin
                    n_sda = 1'b1; n_drv = 1'b0; n_poll = 8'd0;
                    n_phase = PH_WA1; n_timer = tpu_eff; n_units = 2'd2;
                end
                FN_WRITE: begin
                    n_bc = 4'd0; n_drv = 1'b1;
                    n_sda = i_cmd.tx_byte[7];
                    n_shift = {i_cmd.tx_byte[6:0], 1'b0};
                    n_phase = PH_WRHI; n_timer = tpu_eff; n_units = 2'd1;
                end
                FN_READ: begin
                    n_sda = 1'b1; n_drv = 1'b0; n_scl = 1'b0;
                    n_shift = 8'd0; n_bc = 4'd0;
                    n_phase = PH_RDHI; n_timer = tpu_eff; n_units = 2'd2;
                end
                default: begin
                end
            endcase
        end else begin
            run = 1'b1;
            if (r_units != 2'd0) begin
                n_timer = t_dec;
                run = 1'b0;
                if (t_dec == 8'd0) begin
                    n_units = u_dec;
                    if (u_dec != 2'd0) begin
                        n_timer = tpu_eff;
                    end
                    run = (u_dec == 2'd0);
                end
            end
            if (run) begin
                case (r_phase)
                    PH_ST1: begin
                        n_sda = 1'b0;
                        n_phase = PH_ST2; n_timer = tpu_eff; n_units = 2'd2;
                    end
                    PH_ST2: begin
                        n_scl = 1'b0;
                        n_phase = PH_IDLE; n_units = 2'd0; done = 1'b1;
                    end
                    PH_SP1, PH_TO1: begin
                        n_scl = 1'b1; n_sda = 1'b1;
                        n_phase = (r_phase == PH_SP1) ? PH_SP2 : PH_TO2;
                        n_timer = tpu_eff; n_units = 2'd2;
                    end
                    PH_SP2: begin
                        n_phase = PH_IDLE; n_units = 2'd0; done = 1'b1;
                    end
                    PH_TO2: begin
                        n_fail = 1'b1;
                        n_phase = PH_IDLE; n_units = 2'd0; done = 1'b1;
                    end
                    PH_AK1, PH_WA1: begin
                        n_scl = 1'b1;
                        n_phase = (r_phase == PH_AK1) ? PH_AK2 : PH_WA2;
                        n_timer = tpu_eff; n_units = 2'd2;
                    end
                    PH_AK2: begin
                        n_scl = 1'b0;
                        n_phase = PH_IDLE; n_units = 2'd0; done = 1'b1;
                    end
                    PH_WA2: begin
                        if (!i_cmd.sda_in) begin
                            n_scl = 1'b0; n_fail = 1'b0;
                            n_phase = PH_IDLE; n_units = 2'd0; done = 1'b1;
                        end else if (r_poll >= i_limit) begin
                            n_drv = 1'b1; n_scl = 1'b0; n_sda = 1'b0;
                            n_phase = PH_TO1; n_timer = tpu_eff; n_units = 2'd2;
                        end else begin
                            n_poll = r_poll + 8'd1;
                        end
                    end
                    PH_WRSET: begin
                        n_sda = r_shift[7];
                        n_shift = {r_shift[6:0], 1'b0};
                        n_phase = PH_WRHI; n_timer = tpu_eff; n_units = 2'd1;
                    end
                    PH_WRHI: begin
                        n_scl = 1'b1;
                        n_phase = PH_WRLO; n_timer = tpu_eff; n_units = 2'd2;
                    end
                    PH_WRLO: begin
                        n_scl = 1'b0;
                        n_bc = bc_inc;
                        n_phase = (bc_inc >= BITS_PER_BYTE) ? PH_WREND : PH_WRSET;
                        n_timer = tpu_eff; n_units = 2'd1;
                    end
                    PH_WREND: begin
                        n_sda = 1'b1;
                        n_phase = PH_IDLE; n_units = 2'd0; done = 1'b1;
                    end
                    PH_RDHI: begin
                        n_scl = 1'b1;
                        n_phase = PH_RDSMP; n_timer = tpu_eff; n_units = 2'd2;
                    end
                    PH_RDSMP: begin
                        n_shift = sh_in;
                        n_bc = bc_inc;
                        n_scl = 1'b0;
                        if (bc_inc >= BITS_PER_BYTE) begin
                            n_rx = sh_in;
                            n_phase = PH_IDLE; n_units = 2'd0; done = 1'b1;
                        end else begin
                            n_phase = PH_RDHI; n_timer = tpu_eff; n_units = 2'd2;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE; n_units = 2'd0;
                    end
                endcase
            end
        end
    end

    always_comb begin
        o_result.scl_out   = n_scl;
        o_result.sda_out   = n_sda;
        o_result.sda_drive = n_drv;
        o_result.busy_res  = (n_phase != PH_IDLE);
        o_result.done_res  = done;
        o_result.rx_byte   = n_rx;
        o_result.no_ack    = n_fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bc    <= 4'd0;
            r_timer <= 8'd0;
            r_poll  <= 8'd0;
            r_shift <= 8'd0;
            r_rx    <= 8'd0;
            r_fail  <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_drv   <= 1'b0;
            r_units <= 2'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_bc    <= n_bc;
            r_timer <= n_timer;
            r_poll  <= n_poll;
            r_shift <= n_shift;
            r_rx    <= n_rx;
            r_fail  <= n_fail;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_drv   <= n_drv;
            r_units <= n_units;
        end
    end

endmodule

// File: src/i2cm_out_fifo.sv
// Two-entry result queue between the sequencer and the output stream.
module i2cm_out_fifo
    import i2cm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_pop,
    output t_result o_data
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: dv/tb_i2c_master_byte_engine_top.sv
// Testbench for the I2C master byte engine: tick-level prediction of the bus lines and status.
`timescale 1ns / 100ps

module tb_i2c_master_byte_engine_top
    import i2cm_pkg::*;
();

    localparam int CYCLE_LIMIT = 200_000;
    localparam int N_SETS = 5;

    typedef enum logic [4:0] {
        S_IDLE, S_ST1, S_ST2, S_SP1, S_SP2, S_AK1, S_AK2, S_WA1, S_WA2, S_TO1, S_TO2,
        S_WRSET, S_WRHI, S_WRLO, S_WREND, S_RDHI, S_RDSMP
    } seq_e;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata = '0;  // [7:0] tx_byte, [8] sda_in, [15:9] zero
    logic [2:0]        s_axis_tuser = '0;  // [2:0] func
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [15:0]       m_axis_tdata;       // [0] scl, [1] sda, [2] drive, [3] busy, [4] done,
                                           // [12:5] rx_byte, [13] no_ack, [15:14] zero
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [CFG_AW-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    i2c_master_byte_engine_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Bus sequencer shadow state
    seq_e       seq = S_IDLE;
    logic [3:0] bit_cnt = '0;
    logic [7:0] unit_tmr = '0;
    logic [7:0] polls = '0;
    logic [7:0] shreg = '0;
    logic [7:0] rx_last = '0;
    logic       ack_fail = 1'b0;
    logic       scl = 1'b1;
    logic       sda = 1'b1;
    logic       drv = 1'b0;
    logic [1:0] units_left = '0;
    logic [7:0] tpu_cfg = TPU_RESET;
    logic [7:0] limit_cfg = LIMIT_RESET;

    t_cmd    tick_q[$];
    t_result levels_due[$];
    int      ticks_queued = 0;
    int      ticks_taken = 0;
    int      errors = 0;
    int      cycle_cnt = 0;
    int      src_gap = 0;
    int      snk_gap = 0;
    bit      src_burst = 1'b0;
    bit      snk_burst = 1'b0;
    t_result got_res;
    t_result want_res;

    int set_tpu[N_SETS]    = '{1, 0, 2, 3, 1};
    int set_limit[N_SETS]  = '{0, 2, 5, 1, 255};
    int set_budget[N_SETS] = '{48, 32, 32, 16, 32};

    function automatic void load_delay(seq_e nxt, logic [1:0] units);
        seq = nxt;
        unit_tmr = (tpu_cfg == 8'd0) ? 8'd1 : tpu_cfg;
        units_left = units;
    endfunction

    function automatic void shift_out_msb();
        sda = shreg[7];
        shreg = {shreg[6:0], 1'b0};
    endfunction

    function automatic logic run_action(logic sda_i);
        logic fin;
        fin = 1'b0;
        case (seq)
            S_ST1: begin sda = 1'b0; load_delay(S_ST2, 2'd2); end
            S_ST2: begin scl = 1'b0; fin = 1'b1; end
            S_SP1: begin scl = 1'b1; sda = 1'b1; load_delay(S_SP2, 2'd2); end
            S_SP2: fin = 1'b1;
            S_AK1: begin scl = 1'b1; load_delay(S_AK2, 2'd2); end
            S_AK2: begin scl = 1'b0; fin = 1'b1; end
            S_WA1: begin scl = 1'b1; load_delay(S_WA2, 2'd2); end
            S_WA2: begin
                if (!sda_i) begin
                    scl = 1'b0;
                    ack_fail = 1'b0;
                    fin = 1'b1;
                end else if (polls >= limit_cfg) begin
                    drv = 1'b1; scl = 1'b0; sda = 1'b0;
                    load_delay(S_TO1, 2'd2);
                end else begin
                    polls = polls + 8'd1;
                end
            end
            S_TO1: begin scl = 1'b1; sda = 1'b1; load_delay(S_TO2, 2'd2); end
            S_TO2: begin ack_fail = 1'b1; fin = 1'b1; end
            S_WRSET: begin shift_out_msb(); load_delay(S_WRHI, 2'd1); end
            S_WRHI: begin scl = 1'b1; load_delay(S_WRLO, 2'd2); end
            S_WRLO: begin
                scl = 1'b0;
                bit_cnt = bit_cnt + 4'd1;
                load_delay((bit_cnt >= 4'd8) ? S_WREND : S_WRSET, 2'd1);
            end
            S_WREND: begin sda = 1'b1; fin = 1'b1; end
            S_RDHI: begin scl = 1'b1; load_delay(S_RDSMP, 2'd2); end
            S_RDSMP: begin
                shreg = {shreg[6:0], sda_i};
                bit_cnt = bit_cnt + 4'd1;
                scl = 1'b0;
                if (bit_cnt >= 4'd8) begin
                    rx_last = shreg;
                    fin = 1'b1;
                end else begin
                    load_delay(S_RDHI, 2'd2);
                end
            end
            default: begin seq = S_IDLE; units_left = '0; end
        endcase
        if (fin) begin
            seq = S_IDLE;
            units_left = '0;
        end
        return fin;
    endfunction

    function automatic t_result bus_tick(logic [2:0] func, logic [7:0] tx, logic sda_i);
        t_result r;
        logic    fin;
        logic    act_now;
        fin = 1'b0;
        if (seq == S_IDLE) begin
            case (func)
                FN_START: begin
                    drv = 1'b1; sda = 1'b1; scl = 1'b1;
                    load_delay(S_ST1, 2'd2);
                end
                FN_STOP: begin
                    drv = 1'b1; scl = 1'b0; sda = 1'b0;
                    load_delay(S_SP1, 2'd2);
                end
                FN_ACK, FN_NACK: begin
                    scl = 1'b0; drv = 1'b1; sda = (func == FN_NACK);
                    load_delay(S_AK1, 2'd2);
                end
                FN_WAIT: begin
                    sda = 1'b1; drv = 1'b0; polls = '0;
                    load_delay(S_WA1, 2'd2);
                end
                FN_WRITE: begin
                    shreg = tx; bit_cnt = '0; drv = 1'b1;
                    shift_out_msb();
                    load_delay(S_WRHI, 2'd1);
                end
                FN_READ: begin
                    sda = 1'b1; drv = 1'b0; scl = 1'b0; shreg = '0; bit_cnt = '0;
                    load_delay(S_RDHI, 2'd2);
                end
                default: ;
            endcase
        end else begin
            act_now = 1'b1;
            if (units_left != 2'd0) begin
                unit_tmr = unit_tmr - 8'd1;
                if (unit_tmr == 8'd0) begin
                    units_left = units_left - 2'd1;
                    if (units_left != 2'd0)
                        unit_tmr = (tpu_cfg == 8'd0) ? 8'd1 : tpu_cfg;
                end
                act_now = (units_left == 2'd0);
            end
            if (act_now)
                fin = run_action(sda_i);
        end
        r.scl_out   = scl;
        r.sda_out   = sda;
        r.sda_drive = drv;
        r.busy_res  = (seq != S_IDLE);
        r.done_res  = fin;
        r.rx_byte   = rx_last;
        r.no_ack    = ack_fail;
        return r;
    endfunction

    function automatic int pick_gap(inout bit burst);
        int r;
        if ($urandom_range(0, 63) == 0)
            burst = !burst;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    function automatic void check_field(string what, int want, int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
        end
    endfunction

    // Stream driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                levels_due.push_back(bus_tick(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[8]));
                ticks_taken++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (tick_q.size() > 0) begin
                    t_cmd nxt;
                    nxt = tick_q.pop_front();
                    s_axis_tuser  <= nxt.func;
                    s_axis_tdata  <= {7'd0, nxt.sda_in, nxt.tx_byte};
                    s_axis_tvalid <= 1'b1;
                    src_gap = pick_gap(src_burst);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_res = m_axis_tdata[RES_W-1:0];
                if (levels_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual 0x%0h",
                             $time, got_res);
                end else begin
                    want_res = levels_due.pop_front();
                    check_field("scl_out", int'(want_res.scl_out), int'(got_res.scl_out));
                    check_field("sda_out", int'(want_res.sda_out), int'(got_res.sda_out));
                    check_field("sda_drive", int'(want_res.sda_drive),
                                int'(got_res.sda_drive));
                    check_field("busy_res", int'(want_res.busy_res), int'(got_res.busy_res));
                    check_field("done_res", int'(want_res.done_res), int'(got_res.done_res));
                    check_field("rx_byte", int'(want_res.rx_byte), int'(got_res.rx_byte));
                    check_field("no_ack", int'(want_res.no_ack), int'(got_res.no_ack));
                end
            end
            if (snk_gap > 0) begin
                snk_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                snk_gap = pick_gap(snk_burst);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic sda_level(int mode);
        return (mode == 2) ? logic'($urandom_range(0, 1)) : logic'(mode);
    endfunction

    task automatic push_tick(logic [2:0] func, logic [7:0] tx, logic sda_i);
        t_cmd c;
        c.func = func;
        c.tx_byte = tx;
        c.sda_in = sda_i;
        tick_q.push_back(c);
        ticks_queued++;
    endtask

    task automatic wait_taken();
        while (ticks_taken != ticks_queued)
            @(negedge i_clk);
    endtask

    // Issue one command, then feed ticks until it finishes; funcs offered meanwhile must be ignored.
    task automatic run_cmd(logic [2:0] cmd, logic [7:0] tx, int sda_mode);
        push_tick(cmd, tx, sda_level(sda_mode));
        wait_taken();
        while (seq != S_IDLE) begin
            push_tick(3'($urandom_range(0, 7)), 8'($urandom), sda_level(sda_mode));
            wait_taken();
        end
    endtask

    task automatic drain_idle();
        wait_taken();
        while (seq != S_IDLE) begin
            push_tick(FN_NONE, 8'($urandom), 1'($urandom));
            wait_taken();
        end
        while (levels_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic reg_write(logic idx, logic [7:0] val);
        logic [31:0] rd;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_AW'({idx, 2'b00});
        pwdata  <= {24'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[7:0] != val) begin
            errors++;
            $display("%0t: register %0d readback, expected 0x%0h, actual 0x%0h",
                     $time, idx, val, rd[7:0]);
        end
        if (idx == REG_TPU)
            tpu_cfg = val;
        else
            limit_cfg = val;
    endtask

    initial begin
        int   goal;
        logic run_sda;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        reg_write(REG_TPU, 8'd1);
        reg_write(REG_LIMIT, 8'd3);

        run_cmd(FN_NONE, 8'h00, 2);
        run_cmd(FN_START, 8'h00, 2);
        run_cmd(FN_WRITE, 8'hFF, 2);
        run_cmd(FN_WAIT, 8'h00, 0);
        run_cmd(FN_WRITE, 8'h00, 2);
        run_cmd(FN_WAIT, 8'h00, 1);
        run_cmd(FN_START, 8'h00, 2);
        run_cmd(FN_WRITE, 8'hA5, 2);
        run_cmd(FN_WAIT, 8'h00, 2);
        run_cmd(FN_READ, 8'h00, 1);
        run_cmd(FN_ACK, 8'hFF, 2);
        run_cmd(FN_READ, 8'hFF, 0);
        run_cmd(FN_NACK, 8'h00, 2);
        run_cmd(FN_READ, 8'h5A, 2);
        run_cmd(FN_ACK, 8'h00, 2);
        run_cmd(FN_WAIT, 8'h00, 0);
        run_cmd(FN_STOP, 8'h00, 2);
        run_cmd(FN_NACK, 8'h00, 2);
        run_cmd(FN_STOP, 8'h00, 2);
        drain_idle();

        run_sda = 1'b1;
        for (int s = 0; s < N_SETS; s++) begin
            reg_write(REG_TPU, 8'(set_tpu[s]));
            reg_write(REG_LIMIT, 8'(set_limit[s]));
            goal = ticks_queued + set_budget[s];
            while (ticks_queued < goal) begin
                for (int k = 0; k < 16; k++) begin
                    if ($urandom_range(0, 5) == 0)
                        run_sda = !run_sda;
                    push_tick(($urandom_range(0, 3) == 0) ? FN_NONE
                                                          : 3'($urandom_range(1, 7)),
                              8'($urandom), run_sda);
                end
                while (tick_q.size() > 4)
                    @(negedge i_clk);
                if ($urandom_range(0, 3) == 0) begin
                    wait_taken();
                    while (levels_due.size() != 0)
                        @(negedge i_clk);
                end
            end
            drain_idle();
        end

        if (errors == 0 && levels_due.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
